// File: hw/rtl/md5bc_pkg.sv
// shared constants and schedule function of the md5 block compression engine
`default_nettype none

package md5bc_pkg;

  localparam int unsigned WordW = 32;

  // standard initial chaining value
  localparam logic [WordW-1:0] IV_WORDS [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  // sine-derived round constants
  localparam logic [WordW-1:0] SINE_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // rotate amounts, indexed by {phase, round[1:0]}
  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // round function selector
  typedef enum logic [1:0] {
    FN_F = 2'd0,
    FN_G = 2'd1,
    FN_H = 2'd2,
    FN_I = 2'd3
  } round_fn_e;

  // message word index used by a given round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = rnd[3:0];
    case (round_fn_e'(rnd[5:4]))
      FN_F:    idx = r4;
      FN_G:    idx = r4 + {r4[1:0], 2'b00} + 4'd1;
      FN_H:    idx = r4 + {r4[2:0], 1'b0} + 4'd5;
      FN_I:    idx = {r4[0], 3'b000} - r4;
      default: idx = r4;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/md5_block_compress.sv
// md5 block compression engine: word store, round sequencer and chaining value
`default_nettype none

// Message words are taken one per request (start high while busy is low) and
// written into a 16-entry block memory. A word that does not end a block leaves
// busy low. The sixteenth word holds busy high through ST_PRE, which prefetches
// the first message word, 64 rounds at one per cycle through the round unit
// (the block memory is read two rounds ahead so that a + k + w is summed the
// cycle before it is needed), ST_ADD for the chaining add and ST_EMIT, which
// emits the four hash words. Each hash word appears for a single cycle with
// digest_valid_o high, index 0 to 3 in order, the last marked; the receiver
// cannot stall, and the fourth strobe shows in the first idle cycle.
// message_start_i drops any partial block and reloads the initial value.

module md5_block_compress
  import md5bc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WordW-1:0] message_word_i,
  input  wire logic             message_start_i,
  output logic                  digest_valid_o,
  output logic      [WordW-1:0] digest_word_o,
  output logic      [1:0]       digest_index_o,
  output logic                  digest_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [3:0]       cnt_q;
  logic [5:0]       rnd_q;
  logic [1:0]       out_idx_q;
  logic [WordW-1:0] chain_q [4];
  logic [WordW-1:0] a_q, b_q, c_q, d_q;
  logic [WordW-1:0] pre_q, pre_d;
  logic             out_valid_q;
  logic [WordW-1:0] out_word_q;
  logic [1:0]       out_index_q;
  logic             out_last_q;

  logic [WordW-1:0] mem [16];
  logic [WordW-1:0] rd_data_q;
  logic [3:0]       wr_addr;
  logic [5:0]       rd_rnd;
  logic [3:0]       rd_addr;
  logic             accept;
  logic [WordW-1:0] pre_base;
  logic [5:0]       k_idx;
  logic [WordW-1:0] b_next;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign wr_addr = message_start_i ? 4'd0 : cnt_q;

  // read address runs two rounds ahead of the round in progress
  always_comb begin
    case (state_q)
      ST_IDLE:  rd_rnd = 6'd0;
      ST_PRE:   rd_rnd = 6'd1;
      default:  rd_rnd = rnd_q + 6'd2;
    endcase
  end
  assign rd_addr = msg_index(rd_rnd);

  // block word memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wr_addr] <= message_word_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  // a + k + w of the next round, a of the next round is the current d
  assign pre_base = (state_q == ST_PRE) ? a_q : d_q;
  assign k_idx    = (state_q == ST_PRE) ? 6'd0 : rnd_q + 6'd1;
  assign pre_d    = pre_base + SINE_K[k_idx] + rd_data_q;

  // round unit
  md5bc_round u_round (
    .phase_i (rnd_q[5:4]),
    .shift_i (ROT_AMOUNT[{rnd_q[5:4], rnd_q[1:0]}]),
    .b_i     (b_q),
    .c_i     (c_q),
    .d_i     (d_q),
    .pre_i   (pre_q),
    .b_o     (b_next)
  );

  // sequencer, chaining value and round registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      rnd_q       <= 6'd0;
      out_idx_q   <= 2'd0;
      chain_q     <= IV_WORDS;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      d_q         <= '0;
      pre_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_index_q <= 2'd0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (message_start_i) begin
              chain_q <= IV_WORDS;
            end
            cnt_q <= wr_addr + 4'd1;
            if (!message_start_i && cnt_q == 4'd15) begin
              a_q     <= chain_q[0];
              b_q     <= chain_q[1];
              c_q     <= chain_q[2];
              d_q     <= chain_q[3];
              rnd_q   <= 6'd0;
              state_q <= ST_PRE;
            end
          end
        end
        ST_PRE: begin
          pre_q   <= pre_d;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          pre_q <= pre_d;
          a_q   <= d_q;
          b_q   <= b_next;
          c_q   <= b_q;
          d_q   <= c_q;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          out_idx_q  <= 2'd0;
          state_q    <= ST_EMIT;
        end
        ST_EMIT: begin
          out_valid_q <= 1'b1;
          out_word_q  <= chain_q[out_idx_q];
          out_index_q <= out_idx_q;
          out_last_q  <= (out_idx_q == 2'd3);
          out_idx_q   <= out_idx_q + 2'd1;
          if (out_idx_q == 2'd3) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result ports
  assign digest_valid_o = out_valid_q;
  assign digest_word_o  = out_word_q;
  assign digest_index_o = out_index_q;
  assign digest_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/md5bc_round.sv
// one md5 round step: round function, rotate and add into b
`default_nettype none

module md5bc_round
  import md5bc_pkg::*;
(
  input  wire logic [1:0]       phase_i,
  input  wire logic [4:0]       shift_i,
  input  wire logic [WordW-1:0] b_i,
  input  wire logic [WordW-1:0] c_i,
  input  wire logic [WordW-1:0] d_i,
  input  wire logic [WordW-1:0] pre_i,
  output logic      [WordW-1:0] b_o
);

  logic [WordW-1:0]   fn;
  logic [WordW-1:0]   sum;
  logic [2*WordW-1:0] rot_wide;

  // round function of the current phase
  always_comb begin
    case (round_fn_e'(phase_i))
      FN_F:    fn = ((c_i ^ d_i) & b_i) ^ d_i;
      FN_G:    fn = (d_i & b_i) | (~d_i & c_i);
      FN_H:    fn = b_i ^ c_i ^ d_i;
      FN_I:    fn = c_i ^ (b_i | ~d_i);
      default: fn = b_i ^ c_i ^ d_i;
    endcase
  end

  // pre already holds a + k + w, rotate left by doubling the word
  assign sum      = fn + pre_i;
  assign rot_wide = {sum, sum} << shift_i;
  assign b_o      = b_i + rot_wide[2*WordW-1:WordW];

endmodule

`default_nettype wire

// File: tb/sv/md5_block_compress_tb.sv
// self-checking testbench of the md5 block compression engine
`default_nettype none

module md5_block_compress_tb;
  import md5bc_pkg::*;

  // one expected hash word of a block result
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [1:0]       index;
    logic             last;
  } digest_t;

  // scoreboard: own md5 chaining model plus the queue of expected hash words
  class md5_chain_tracker;
    logic [WordW-1:0] msg_store [16];
    logic [WordW-1:0] chain [4];
    logic [WordW-1:0] round_k [64];
    int unsigned      shift_amt [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                         4, 11, 16, 23, 6, 10, 15, 21};
    logic [3:0]       fill_pos;
    digest_t          pending_digest [$];
    int unsigned      fail_count;
    int unsigned      digests_seen;
    int unsigned      blocks_hashed;

    function new();
      real s;
      // round constants from the sine derivation
      for (int i = 0; i < 64; i++) begin
        s = $sin(i + 1);
        if (s < 0.0) s = -s;
        round_k[i] = WordW'(longint'($floor(s * 4294967296.0)));
      end
      for (int i = 0; i < 16; i++) msg_store[i] = '0;
      load_iv();
      fill_pos = '0;
      fail_count = 0;
      digests_seen = 0;
      blocks_hashed = 0;
    endfunction

    function void load_iv();
      chain[0] = 32'h67452301;
      chain[1] = 32'hEFCDAB89;
      chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476;
    endfunction

    function logic [WordW-1:0] rotl(logic [WordW-1:0] x, int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    // 64 rounds over the gathered block, added into the chaining value
    function void hash_block();
      logic [WordW-1:0] a, b, c, d, f, t, nb;
      int unsigned g;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = r % 16;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        t  = a + f + round_k[r] + msg_store[g];
        nb = b + rotl(t, shift_amt[(r / 16) * 4 + r % 4]);
        a = d;
        d = c;
        c = b;
        b = nb;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // accepted word request: store it, hash on the sixteenth
    function void note_word(logic [WordW-1:0] w, logic first);
      digest_t e;
      if (first) begin
        load_iv();
        fill_pos = '0;
      end
      msg_store[fill_pos] = w;
      if (fill_pos != 4'd15) begin
        fill_pos++;
      end else begin
        fill_pos = '0;
        hash_block();
        blocks_hashed++;
        for (int k = 0; k < 4; k++) begin
          e.word  = chain[k];
          e.index = 2'(k);
          e.last  = (k == 3);
          pending_digest.push_back(e);
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
    endtask

    // compare one strobed hash word with the oldest expectation
    task check_digest(logic [WordW-1:0] w, logic [1:0] idx, logic last);
      digest_t e;
      digests_seen++;
      if (pending_digest.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d", w, idx));
      end else begin
        e = pending_digest.pop_front();
        if (w !== e.word)
          report_mismatch($sformatf("digest word %h, want %h (index %0d)", w, e.word, e.index));
        if (idx !== e.index)
          report_mismatch($sformatf("digest index %0d, want %0d", idx, e.index));
        if (last !== e.last)
          report_mismatch($sformatf("digest last %b, want %b (index %0d)", last, e.last,
                                    e.index));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [WordW-1:0] msg_word;
  logic             msg_first;
  logic             digest_valid;
  logic [WordW-1:0] digest_word;
  logic [1:0]       digest_index;
  logic             digest_last;

  md5_chain_tracker sb;
  int unsigned      idle_pct;
  int unsigned      words_sent;
  int unsigned      starts_sent;

  md5_block_compress dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .message_word_i  (msg_word),
    .message_start_i (msg_first),
    .digest_valid_o  (digest_valid),
    .digest_word_o   (digest_word),
    .digest_index_o  (digest_index),
    .digest_last_o   (digest_last)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && digest_valid === 1'b1) sb.check_digest(digest_word, digest_index, digest_last);
  end

  // random word with a bias toward the extremes
  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return WordW'(1) << $urandom_range(31);
      3:       return ~(WordW'(1) << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // one word request, with random sender gaps ahead of it
  task automatic send_word(input logic [WordW-1:0] w, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start     = 1'b1;
    msg_word  = w;
    msg_first = first;
    do @(posedge clk_i); while (busy);
    sb.note_word(w, first);
    words_sent++;
    if (first) starts_sent++;
  endtask

  // run of random words, the first one optionally carrying start
  task automatic send_run(input int unsigned len, input logic first);
    for (int i = 0; i < len; i++) send_word(pick_word(), first && i == 0);
  endtask

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for the block");
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned phase_idle [4];
    int unsigned quota;
    phase_idle  = '{0, 63, 0, 26};
    sb = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    msg_word    = '0;
    msg_first   = 1'b0;
    idle_pct    = 0;
    words_sent  = 0;
    starts_sent = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full block after reset with no start, chaining from the iv
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_word('1, 1'b0);
        1: send_word('0, 1'b0);
        2: send_word(32'h80000000, 1'b0);
        default: send_word(32'h00000001, 1'b0);
      endcase
    end
    // directed: partial blocks dropped by a start in mid-block
    send_word('1, 1'b1);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(32'h00000080, 1'b1);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(32'h7FFFFFFF, 1'b0);

    // random: mostly whole messages, some continued and some broken blocks
    quota = 280;
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      while (words_sent < quota * (p + 1) / 4) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: send_run(16 * $urandom_range(1, 3), 1'b1);
          6, 7:             send_run(16, 1'b0);
          default:          send_run($urandom_range(1, 15), $urandom_range(1));
        endcase
      end
    end
    @(negedge clk_i);
    start = 1'b0;

    // drain, then look for stray strobes for longer than one block takes
    while (sb.pending_digest.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("sent %0d word requests (%0d with start), hashed %0d blocks, checked %0d words",
             words_sent, starts_sent, sb.blocks_hashed, sb.digests_seen);
    if (sb.pending_digest.size() != 0)
      sb.report_mismatch($sformatf("%0d digest words never came", sb.pending_digest.size()));
    if (sb.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
